/* rtl/sbb_pkg.sv */
// Shared constants for the separable box blur unit.
// Holds field widths, register indexes and default size limits.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
package sbb_pkg;

  localparam int PIX_W      = 32;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int DIM_W      = 11;
  localparam int RAD_W      = 5;
  // Position arithmetic: a clamped size plus a radius always fits.
  localparam int POS_W      = 13;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_RADIUS = 16;

  // Register indexes of the configuration channel.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUR_HALF_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_ONLY      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_BYTE_HIGH = 3'd4;

  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 11'd64;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 11'd64;
  localparam logic [RAD_W-1:0] RST_HALF_WIDTH   = 5'd1;

  // Request kinds on the input channel.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

endpackage

/* rtl/sbb_in_if.sv */
// Input channel of the blur unit: valid, ready, operation and pixel.
// Depends on sbb_pkg for the field widths.
`timescale 1ns / 1ps
interface sbb_in_if;
  import sbb_pkg::*;
  logic             valid;
  logic             ready;
  logic             operation;
  logic [PIX_W-1:0] pixel_in;
  modport source (output valid, output operation, output pixel_in, input ready);
  modport sink (input valid, input operation, input pixel_in, output ready);
endinterface

/* rtl/sbb_out_if.sv */
// Output channel of the blur unit: valid, ready, blurred pixel and frame end.
// Depends on sbb_pkg for the field widths.
`timescale 1ns / 1ps
interface sbb_out_if;
  import sbb_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             frame_end;
  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

/* rtl/sbb_cfg_if.sv */
// Configuration write channel: valid, ready, register index and data.
// Depends on sbb_pkg for the field widths.
`timescale 1ns / 1ps
interface sbb_cfg_if;
  import sbb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/separable_box_blur_unit.sv */
// Separable box blur with clamp-to-edge, streamed in raster order.
// Depends on sbb_pkg and the interfaces sbb_in_if, sbb_out_if and sbb_cfg_if.
`timescale 1ns / 1ps
// The unit takes one request at a time. A pixel request is written into a
// small ring of raw pixels; every horizontally blurred column it completes is
// then worked out by a sequencer that reads the 2R+1 window taps from that
// ring one by one, divides the four byte sums by 2R+1 in a shared restoring
// divider of SW steps (SW = 14 at the default radius limit) and writes the
// result into the line memory. After that, if the next output pixel has all
// its inputs, the same sequencer reads its 2R+1 vertical taps from the line
// memory and divides again. A pixel request completes no column early in a
// row, one, or up to R+1 at the end of a row; a drain request completes none
// and may yield an output pixel. A finished pixel waits in an output
// register, and the next request is taken meanwhile; the sequencer stalls
// only when a second pixel is ready before the first has left. Register
// writes are taken only while the sequencer is idle, take effect at once and
// restart the frame. Neither memory is cleared after reset.
module separable_box_blur_unit #(
  parameter int MAX_WIDTH  = sbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sbb_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = sbb_pkg::DEF_MAX_RADIUS
) (
  input logic       clk,
  input logic       rst,
  sbb_in_if.sink    src,
  sbb_out_if.source dst,
  sbb_cfg_if.sink   cfg
);
  import sbb_pkg::*;

  localparam int RING     = 2 * MAX_RADIUS + 2;
  localparam int IW       = $clog2(RING);
  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int RW       = $clog2(MAX_HEIGHT + 1);
  localparam int SW       = $clog2((2 * MAX_RADIUS + 1) * 255 + 1);
  localparam int DW       = $clog2(2 * MAX_RADIUS + 2);
  localparam int HB_DEPTH = RING * MAX_WIDTH;
  localparam int HAW      = $clog2(HB_DEPTH);
  localparam int SCW      = $clog2(SW);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_START = 4'd1;
  localparam logic [3:0] ST_RD    = 4'd2;
  localparam logic [3:0] ST_ACC   = 4'd3;
  localparam logic [3:0] ST_DIV   = 4'd4;
  localparam logic [3:0] ST_DONE  = 4'd5;
  localparam logic [3:0] ST_ADV   = 4'd6;
  localparam logic [3:0] ST_CHECK = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  function automatic logic [IW-1:0] ring_back(input logic [IW-1:0] m,
                                              input logic [POS_W-1:0] r);
    logic [IW:0] t;
    t = (IW+1)'(m) + (IW+1)'(RING) - r[IW:0];
    if (t >= (IW+1)'(RING)) t = t - (IW+1)'(RING);
    return t[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] m);
    return (m == IW'(RING - 1)) ? '0 : m + IW'(1);
  endfunction

  // Configuration registers.
  logic [DIM_W-1:0] frame_width, frame_height;
  logic [RAD_W-1:0] blur_half_width;
  logic             alpha_only, alpha_byte_high;

  // Frame position counters and their ring positions.
  logic [CW-1:0] in_col, out_col;
  logic [RW-1:0] in_row, out_row;
  logic [IW-1:0] in_col_mod, in_row_mod, out_row_mod;

  // Sequencer state.
  logic [3:0]       state;
  logic             vert, keep_phase;
  logic [POS_W-1:0] tap_cnt, pos, lead;
  logic [IW-1:0]    pmod;
  logic [POS_W-1:0] hx, hx_end;
  logic [IW-1:0]    hx_mod;
  logic [SW-1:0]    sums [NUM_CH];
  logic [SW-1:0]    dvd  [NUM_CH];
  logic [DW-1:0]    rem  [NUM_CH];
  logic [CH_W-1:0]  quot [NUM_CH];
  logic [SCW-1:0]   dcnt;
  logic [PIX_W-1:0] keepv;

  // Output register.
  logic             ovalid, oend;
  logic [PIX_W-1:0] opix, res;

  // Memories.
  logic [PIX_W-1:0] row_window  [RING];
  logic [PIX_W-1:0] hblur_lines [HB_DEPTH];
  logic [PIX_W-1:0] rw_q, hb_q;

  // Clamped sizes, divisor and blur mask.
  logic [POS_W-1:0] w_c, h_c, rad, two_rad;
  logic [DW-1:0]    divisor;
  logic [NUM_CH-1:0] mask;

  always_comb begin
    if (frame_width == '0) w_c = POS_W'(1);
    else if (POS_W'(frame_width) > POS_W'(MAX_WIDTH)) w_c = POS_W'(MAX_WIDTH);
    else w_c = POS_W'(frame_width);
    if (frame_height == '0) h_c = POS_W'(1);
    else if (POS_W'(frame_height) > POS_W'(MAX_HEIGHT)) h_c = POS_W'(MAX_HEIGHT);
    else h_c = POS_W'(frame_height);
    if (blur_half_width == '0) rad = POS_W'(1);
    else if (POS_W'(blur_half_width) > POS_W'(MAX_RADIUS)) rad = POS_W'(MAX_RADIUS);
    else rad = POS_W'(blur_half_width);
    two_rad = rad << 1;
    divisor = DW'(two_rad + POS_W'(1));
    if (alpha_only) mask = alpha_byte_high ? 4'b1000 : 4'b0001;
    else mask = 4'b1111;
  end

  // Request decode on the input side.
  logic             in_acc, pix_take, cur_last, has_first;
  logic [POS_W-1:0] c_ext;

  // A register write waiting at the idle sequencer goes before the next request.
  assign src.ready = (state == ST_IDLE) && !cfg.valid;
  assign cfg.ready = (state == ST_IDLE);
  assign in_acc    = src.valid && src.ready;
  assign c_ext     = POS_W'(in_col);
  assign pix_take  = in_acc && (src.operation == OP_PIXEL) && (POS_W'(in_row) < h_c);
  assign cur_last  = (c_ext + POS_W'(1)) >= w_c;
  assign has_first = c_ext >= rad;

  // Window start for the current pass.
  logic [POS_W-1:0] base;
  logic [IW-1:0]    base_mod;
  logic [POS_W-1:0] lim;

  assign base     = vert ? POS_W'(out_row) : hx;
  assign base_mod = vert ? out_row_mod : hx_mod;
  assign lim      = vert ? (h_c - POS_W'(1)) : (w_c - POS_W'(1));

  // Memory addresses and combined result.
  logic [IW-1:0]    rw_raddr;
  logic [IW-1:0]    hb_row;
  logic [HAW-1:0]   hb_raddr, hb_waddr;
  logic             hb_we;
  logic [PIX_W-1:0] tap_data, combined;

  assign rw_raddr = keep_phase ? hx_mod : pmod;
  assign hb_row   = keep_phase ? out_row_mod : pmod;
  assign hb_raddr = HAW'(hb_row) * HAW'(MAX_WIDTH) + HAW'(out_col);
  assign hb_waddr = HAW'(in_row_mod) * HAW'(MAX_WIDTH) + HAW'(hx);
  assign hb_we    = (state == ST_DONE) && !vert;
  assign tap_data = vert ? hb_q : rw_q;

  always_comb begin
    combined = '0;
    for (int b = 0; b < NUM_CH; b++) begin
      combined[b*CH_W +: CH_W] = mask[b] ? quot[b] : keepv[b*CH_W +: CH_W];
    end
  end

  // One restoring division step on all four channels.
  logic [DW-1:0]   rem_step  [NUM_CH];
  logic [NUM_CH-1:0] qbit;

  always_comb begin
    logic [DW:0] sh;
    for (int b = 0; b < NUM_CH; b++) begin
      sh = {rem[b], dvd[b][SW-1]};
      if (sh >= (DW+1)'(divisor)) begin
        rem_step[b] = DW'(sh - (DW+1)'(divisor));
        qbit[b]     = 1'b1;
      end else begin
        rem_step[b] = sh[DW-1:0];
        qbit[b]     = 1'b0;
      end
    end
  end

  // Output readiness test.
  logic [POS_W-1:0] need_row, need_col, orow_rad, ocol_rad;
  logic             out_ok, out_last, out_load;

  always_comb begin
    orow_rad = POS_W'(out_row) + rad;
    ocol_rad = POS_W'(out_col) + rad;
    need_row = (orow_rad < h_c - POS_W'(1)) ? orow_rad : h_c - POS_W'(1);
    need_col = (ocol_rad < w_c - POS_W'(1)) ? ocol_rad : w_c - POS_W'(1);
    out_ok   = (POS_W'(in_row) > need_row) ||
               ((POS_W'(in_row) == need_row) && (c_ext > need_col));
    out_last = ((POS_W'(out_row) + POS_W'(1)) >= h_c) &&
               ((POS_W'(out_col) + POS_W'(1)) >= w_c);
  end

  // The finished pixel moves into the output register once that is free.
  assign out_load = (state == ST_OUT) && (!ovalid || dst.ready);

  // Raw pixel ring: written on an accepted pixel, read by the horizontal pass.
  always_ff @(posedge clk) begin
    if (pix_take) row_window[in_col_mod] <= src.pixel_in;
    rw_q <= row_window[rw_raddr];
  end

  // Line memory of horizontally blurred pixels.
  always_ff @(posedge clk) begin
    if (hb_we) hblur_lines[hb_waddr] <= combined;
    hb_q <= hblur_lines[hb_raddr];
  end

  // Payload registers of the sequencer.
  always_ff @(posedge clk) begin
    case (state)
      ST_START: begin
        keep_phase <= 1'b1;
        tap_cnt    <= '0;
        for (int b = 0; b < NUM_CH; b++) sums[b] <= '0;
        if (base >= rad) begin
          pos  <= base - rad;
          pmod <= ring_back(base_mod, rad);
          lead <= '0;
        end else begin
          pos  <= '0;
          pmod <= '0;
          lead <= rad - base;
        end
      end
      ST_ACC: begin
        if (keep_phase) begin
          keepv      <= tap_data;
          keep_phase <= 1'b0;
        end else begin
          for (int b = 0; b < NUM_CH; b++) begin
            sums[b] <= sums[b] + SW'(tap_data[b*CH_W +: CH_W]);
          end
          tap_cnt <= tap_cnt + POS_W'(1);
          if (lead != '0) begin
            lead <= lead - POS_W'(1);
          end else if (pos < lim) begin
            pos  <= pos + POS_W'(1);
            pmod <= ring_inc(pmod);
          end
          if (tap_cnt == two_rad) begin
            for (int b = 0; b < NUM_CH; b++) begin
              dvd[b]  <= sums[b] + SW'(tap_data[b*CH_W +: CH_W]);
              rem[b]  <= '0;
              quot[b] <= '0;
            end
            dcnt <= '0;
          end
        end
      end
      ST_DIV: begin
        for (int b = 0; b < NUM_CH; b++) begin
          rem[b]  <= rem_step[b];
          dvd[b]  <= dvd[b] << 1;
          quot[b] <= {quot[b][CH_W-2:0], qbit[b]};
        end
        dcnt <= dcnt + SCW'(1);
      end
      ST_DONE: begin
        res <= combined;
      end
      default: begin
      end
    endcase
  end

  // Control state, counters, configuration and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      vert            <= 1'b0;
      frame_width     <= RST_FRAME_WIDTH;
      frame_height    <= RST_FRAME_HEIGHT;
      blur_half_width <= RST_HALF_WIDTH;
      alpha_only      <= 1'b0;
      alpha_byte_high <= 1'b0;
      in_col          <= '0;
      in_row          <= '0;
      out_col         <= '0;
      out_row         <= '0;
      in_col_mod      <= '0;
      in_row_mod      <= '0;
      out_row_mod     <= '0;
      hx              <= '0;
      hx_end          <= '0;
      hx_mod          <= '0;
      ovalid          <= 1'b0;
    end else begin
      if (out_load) ovalid <= 1'b1;
      else if (dst.ready) ovalid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (pix_take) begin
              if (has_first || cur_last) begin
                hx     <= has_first ? c_ext - rad : '0;
                hx_mod <= has_first ? ring_back(in_col_mod, rad) : '0;
                hx_end <= cur_last ? w_c - POS_W'(1) : c_ext - rad;
                vert   <= 1'b0;
                state  <= ST_START;
              end else begin
                state <= ST_ADV;
              end
            end else begin
              state <= ST_CHECK;
            end
          end
        end
        ST_START: state <= ST_RD;
        ST_RD:    state <= ST_ACC;
        ST_ACC: begin
          if (!keep_phase && tap_cnt == two_rad) state <= ST_DIV;
          else state <= ST_RD;
        end
        ST_DIV: begin
          if (dcnt == SCW'(SW - 1)) state <= ST_DONE;
        end
        ST_DONE: begin
          if (vert) begin
            state <= ST_OUT;
          end else if (hx == hx_end) begin
            state <= ST_ADV;
          end else begin
            hx     <= hx + POS_W'(1);
            hx_mod <= ring_inc(hx_mod);
            state  <= ST_START;
          end
        end
        ST_ADV: begin
          if (cur_last) begin
            in_col     <= '0;
            in_col_mod <= '0;
            in_row     <= in_row + RW'(1);
            in_row_mod <= ring_inc(in_row_mod);
          end else begin
            in_col     <= in_col + CW'(1);
            in_col_mod <= ring_inc(in_col_mod);
          end
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (POS_W'(out_row) < h_c && out_ok) begin
            vert  <= 1'b1;
            state <= ST_START;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            opix   <= res;
            oend   <= out_last;
            if (out_last) begin
              in_col      <= '0;
              in_row      <= '0;
              out_col     <= '0;
              out_row     <= '0;
              in_col_mod  <= '0;
              in_row_mod  <= '0;
              out_row_mod <= '0;
            end else if ((POS_W'(out_col) + POS_W'(1)) >= w_c) begin
              out_col     <= '0;
              out_row     <= out_row + RW'(1);
              out_row_mod <= ring_inc(out_row_mod);
            end else begin
              out_col <= out_col + CW'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      // A register write to a defined index restarts the frame.
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_FRAME_WIDTH:     frame_width     <= cfg.data[DIM_W-1:0];
          CFG_FRAME_HEIGHT:    frame_height    <= cfg.data[DIM_W-1:0];
          CFG_BLUR_HALF_WIDTH: blur_half_width <= cfg.data[RAD_W-1:0];
          CFG_ALPHA_ONLY:      alpha_only      <= cfg.data[0];
          CFG_ALPHA_BYTE_HIGH: alpha_byte_high <= cfg.data[0];
          default: begin
          end
        endcase
        if (cfg.index <= CFG_ALPHA_BYTE_HIGH) begin
          in_col      <= '0;
          in_row      <= '0;
          out_col     <= '0;
          out_row     <= '0;
          in_col_mod  <= '0;
          in_row_mod  <= '0;
          out_row_mod <= '0;
        end
      end
    end
  end

  assign dst.valid     = ovalid;
  assign dst.pixel_out = opix;
  assign dst.frame_end = oend;

  // Output never overtakes the input rows it depends on.
  a_out_behind_in: assert property (@(posedge clk) disable iff (rst)
    out_row <= in_row)
    else $error("output row ahead of input row");

  // The horizontal pass stays inside its column range.
  a_hx_range: assert property (@(posedge clk) disable iff (rst)
    (!vert && (state == ST_RD || state == ST_ACC)) |-> hx <= hx_end)
    else $error("horizontal column beyond range end");

  // The ring position of the input column is zero whenever the column counter is zero.
  a_col_ring: assert property (@(posedge clk) disable iff (rst)
    (in_col == '0) |-> (in_col_mod == '0))
    else $error("input column ring position out of step");

endmodule
